// ===== src/etfp_pkg.sv =====
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and palette helpers for the escape-time pixel unit.
// ----------------------------------------------------------------------------
package etfp_pkg;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int COLOR_W     = 8;
  localparam int COUNT_W     = 10;
  localparam int STEP_W      = 31;
  localparam int PALETTE_W   = 24;
  localparam int VAL_W       = 32;
  localparam int MUL_OP_W    = 33;
  localparam int PIXEL_BITS  = 12;

  // count*255 needs COUNT_W + 8 bits; one quotient bit per divider cycle
  localparam int DIVIDEND_W  = COUNT_W + 8;
  localparam int DIV_CNT_W   = 5;

  localparam logic [COLOR_W-1:0] IDX_MAX   = 8'd255;
  localparam logic [COLOR_W-1:0] RAMP_CAP  = 8'd253;
  localparam logic [COLOR_W-1:0] SEG_G_LO  = 8'd85;
  localparam logic [COLOR_W-1:0] SEG_B_LO  = 8'd170;
  localparam logic [6:0]         SEG_LEN   = 7'd85;

  localparam logic [COUNT_W-1:0]    RST_MAX_ITERATIONS = 10'd250;
  localparam logic [VAL_W-1:0]      RST_ORIGIN_RE      = 32'hD800_0000;
  localparam logic [VAL_W-1:0]      RST_ORIGIN_IM      = 32'hE800_0000;
  localparam logic [STEP_W-1:0]     RST_PIXEL_STEP     = 31'd1342177;
  localparam logic [VAL_W-1:0]      RST_START_RE       = 32'h0000_0000;
  localparam logic [VAL_W-1:0]      RST_START_IM       = 32'h0000_0000;
  localparam logic [PALETTE_W-1:0]  RST_PALETTE_STARTS = 24'h00_1522;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_ITERATIONS = 3'd0,
    CFG_ORIGIN_RE      = 3'd1,
    CFG_ORIGIN_IM      = 3'd2,
    CFG_PIXEL_STEP     = 3'd3,
    CFG_START_RE       = 3'd4,
    CFG_START_IM       = 3'd5,
    CFG_PALETTE_STARTS = 3'd6
  } cfg_idx_t;

  // v mod 3 via base-4 digit sums (4 == 1 mod 3)
  function automatic logic [1:0] mod3_u8(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, v[7:6]} + {2'b00, v[5:4]} + {2'b00, v[3:2]} + {2'b00, v[1:0]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // steps taken inside one ramp segment starting at entry lo
  function automatic logic [6:0] ramp_steps(input logic [7:0] idx, input logic [7:0] lo);
    logic [7:0] d;
    d = idx - lo;
    if (idx <= lo) begin
      return 7'd0;
    end else if (d >= 8'(SEG_LEN)) begin
      return SEG_LEN;
    end else begin
      return d[6:0];
    end
  endfunction

  // level after k increments of 3, each taken only while below the cap
  function automatic logic [7:0] ramp_level(input logic [7:0] start, input logic [6:0] k);
    logic [9:0] t;
    logic [7:0] lvl;
    t = 10'(start) + 10'({k, 1'b0}) + 10'(k);
    if (start >= RAMP_CAP) begin
      lvl = start;
    end else if (t < 10'(RAMP_CAP)) begin
      lvl = t[7:0];
    end else begin
      // first level at or above the cap keeps the residue of start
      case (mod3_u8(start))
        2'd1:    lvl = RAMP_CAP;
        2'd2:    lvl = RAMP_CAP + 8'd1;
        default: lvl = RAMP_CAP + 8'd2;
      endcase
    end
    return lvl;
  endfunction

endpackage

// ===== src/etfp_if.sv =====
// ----------------------------------------------------------------------------
// etfp_if
// Pixel and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface etfp_in_if import etfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface etfp_out_if import etfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COUNT_W-1:0] iteration_count;
  logic               inside_res;

  modport source (output valid, output red, output green, output blue,
                  output iteration_count, output inside_res, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input iteration_count, input inside_res, output ready);
endinterface

// ===== src/escape_time_fractal_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// Escape-time fractal pixel: z = z*z + c on one shared multiplier, ramp color.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one pixel item (pixel_x, pixel_y); out_chan returns one
//   result item (red, green, blue, iteration_count, inside_res) per pixel.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequence:
//   One pixel at a time. A single 33x33 signed multiplier is time-shared:
//   states S_CRE, S_CIM and S_CSAT form c, then each iteration runs z.re^2,
//   z.im^2, z.re*z.im and the update in turn, and a final pass of the squares
//   ends in the escape test. An escaped pixel then runs a shift-subtract
//   divider for the ramp index. in_chan.ready is high only while the
//   sequencer is idle, so a new item is taken only after the last one has
//   been written back to the output register.
// Reset:
//   Synchronous; registers return to their defaults and no item is held.
// Stall:
//   A result waits in the output register; the next pixel is taken and
//   computed meanwhile, and holds before writeback until the register frees.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
  parameter int FRAC_BITS  = 28
) (
  input  logic                   clk,
  input  logic                   rst_n,
  etfp_in_if.sink                in_chan,
  etfp_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PW = 2 * MUL_OP_W;          // full product width
  localparam int SW = 65 - FRAC_BITS;        // scaled square / cross width

  localparam logic signed [PW-1:0] FOUR  = PW'(4) << FRAC_BITS;
  localparam logic signed [PW-1:0] S_MAX = (PW'(1) << (VAL_W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] S_MIN = -(PW'(1) << (VAL_W - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_CRE, S_CIM, S_CSAT, S_SQA, S_SQB, S_CROSS, S_UPD, S_DIV, S_OUT
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PW-1:0] v);
    if (v > S_MAX) begin
      return S_MAX[VAL_W-1:0];
    end else if (v < S_MIN) begin
      return S_MIN[VAL_W-1:0];
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

  // configuration
  logic [COUNT_W-1:0]       max_iter_r;
  logic signed [VAL_W-1:0]  origin_re_r;
  logic signed [VAL_W-1:0]  origin_im_r;
  logic [STEP_W-1:0]        pixel_step_r;
  logic signed [VAL_W-1:0]  start_re_r;
  logic signed [VAL_W-1:0]  start_im_r;
  logic [PALETTE_W-1:0]     palette_r;

  // datapath
  state_t                   state_r;
  logic [PIXEL_BITS-1:0]    px_r;
  logic [PIXEL_BITS-1:0]    py_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [VAL_W-1:0]  cre_r;
  logic signed [VAL_W-1:0]  cim_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [VAL_W-1:0]  b_r;
  logic signed [SW-1:0]     aa_r;
  logic signed [SW-1:0]     bb_r;
  logic signed [SW-1:0]     ab_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     inside_r;
  logic [DIVIDEND_W-1:0]    quo_r;
  logic [COUNT_W-1:0]       rem_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  // output register
  logic                     out_valid_r;
  logic [COLOR_W-1:0]       red_r;
  logic [COLOR_W-1:0]       green_r;
  logic [COLOR_W-1:0]       blue_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_inside_r;

  // shared multiplier
  logic signed [MUL_OP_W-1:0] op_a;
  logic signed [MUL_OP_W-1:0] op_b;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       sq_sh;
  logic signed [PW-1:0]       cr_sh;

  always_comb begin
    case (state_r)
      S_CRE: begin
        op_a = $signed({{(MUL_OP_W - PIXEL_BITS){1'b0}}, px_r});
        op_b = $signed({{(MUL_OP_W - STEP_W){1'b0}}, pixel_step_r});
      end
      S_CIM: begin
        op_a = $signed({{(MUL_OP_W - PIXEL_BITS){1'b0}}, py_r});
        op_b = $signed({{(MUL_OP_W - STEP_W){1'b0}}, pixel_step_r});
      end
      S_SQB: begin
        op_a = $signed({b_r[VAL_W-1], b_r});
        op_b = $signed({b_r[VAL_W-1], b_r});
      end
      S_CROSS: begin
        op_a = $signed({a_r[VAL_W-1], a_r});
        op_b = $signed({b_r[VAL_W-1], b_r});
      end
      default: begin
        op_a = $signed({a_r[VAL_W-1], a_r});
        op_b = $signed({a_r[VAL_W-1], a_r});
      end
    endcase
  end

  assign prod  = op_a * op_b;
  assign sq_sh = prod >>> FRAC_BITS;
  assign cr_sh = prod >>> (FRAC_BITS - 1);

  // escape / limit test on the squares of the current z
  logic signed [PW-1:0] mag;
  logic                 at_limit;
  logic                 finish;
  assign mag      = PW'(aa_r) + PW'(bb_r);
  assign at_limit = (count_r == max_iter_r);
  assign finish   = ((count_r != '0) && (mag > FOUR)) || at_limit;

  logic signed [PW-1:0] re_sum;
  logic signed [PW-1:0] im_sum;
  assign re_sum = PW'(aa_r) - PW'(bb_r) + PW'(cre_r);
  assign im_sum = PW'(ab_r) + PW'(cim_r);

  // divider step
  logic [COUNT_W:0]   trial;
  logic               q_bit;
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign q_bit = (trial >= {1'b0, max_iter_r - COUNT_W'(1)});

  // palette
  logic [COLOR_W-1:0] ramp_idx;
  logic [COLOR_W-1:0] red_nxt;
  logic [COLOR_W-1:0] green_nxt;
  logic [COLOR_W-1:0] blue_nxt;
  logic               out_free;

  always_comb begin
    ramp_idx = (quo_r > DIVIDEND_W'(IDX_MAX)) ? IDX_MAX : quo_r[COLOR_W-1:0];
    if (inside_r) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = ramp_level(palette_r[23:16], ramp_steps(ramp_idx, 8'd0));
      green_nxt = ramp_level(palette_r[15:8], ramp_steps(ramp_idx, SEG_G_LO));
      blue_nxt  = ramp_level(palette_r[7:0], ramp_steps(ramp_idx, SEG_B_LO));
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r   <= RST_MAX_ITERATIONS;
      origin_re_r  <= RST_ORIGIN_RE;
      origin_im_r  <= RST_ORIGIN_IM;
      pixel_step_r <= RST_PIXEL_STEP;
      start_re_r   <= RST_START_RE;
      start_im_r   <= RST_START_IM;
      palette_r    <= RST_PALETTE_STARTS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_ITERATIONS: max_iter_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_ORIGIN_RE:      origin_re_r  <= cfg_wdata;
        CFG_ORIGIN_IM:      origin_im_r  <= cfg_wdata;
        CFG_PIXEL_STEP:     pixel_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_START_RE:       start_re_r   <= cfg_wdata;
        CFG_START_IM:       start_im_r   <= cfg_wdata;
        CFG_PALETTE_STARTS: palette_r    <= cfg_wdata[PALETTE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the writeback below decides the output valid
      if (out_valid_r && out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            px_r    <= in_chan.pixel_x;
            py_r    <= in_chan.pixel_y;
            a_r     <= start_re_r;
            b_r     <= start_im_r;
            count_r <= '0;
            state_r <= S_CRE;
          end
        end
        S_CRE: begin
          prod_r  <= prod;
          state_r <= S_CIM;
        end
        S_CIM: begin
          cre_r   <= sat32(PW'(origin_re_r) + prod_r);
          prod_r  <= prod;
          state_r <= S_CSAT;
        end
        S_CSAT: begin
          cim_r   <= sat32(PW'(origin_im_r) + prod_r);
          state_r <= S_SQA;
        end
        S_SQA: begin
          aa_r    <= sq_sh[SW-1:0];
          state_r <= S_SQB;
        end
        S_SQB: begin
          bb_r    <= sq_sh[SW-1:0];
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          if (finish) begin
            inside_r <= at_limit;
            // count*255 = count*256 - count
            quo_r     <= {count_r, 8'd0} - DIVIDEND_W'(count_r);
            rem_r     <= '0;
            div_cnt_r <= DIV_CNT_W'(DIVIDEND_W - 1);
            state_r   <= at_limit ? S_OUT : S_DIV;
          end else begin
            ab_r    <= cr_sh[SW-1:0];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          a_r     <= sat32(re_sum);
          b_r     <= sat32(im_sum);
          count_r <= count_r + COUNT_W'(1);
          state_r <= S_SQA;
        end
        S_DIV: begin
          rem_r <= q_bit ? (trial[COUNT_W-1:0] - (max_iter_r - COUNT_W'(1)))
                         : trial[COUNT_W-1:0];
          quo_r <= {quo_r[DIVIDEND_W-2:0], q_bit};
          if (div_cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            red_r        <= red_nxt;
            green_r      <= green_nxt;
            blue_r       <= blue_nxt;
            out_count_r  <= count_r;
            out_inside_r <= inside_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready            = (state_r == S_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.red             = red_r;
  assign out_chan.green           = green_r;
  assign out_chan.blue            = blue_r;
  assign out_chan.iteration_count = out_count_r;
  assign out_chan.inside_res      = out_inside_r;

endmodule

// ===== src/etfp_checker.sv =====
// ----------------------------------------------------------------------------
// etfp_checker
// Port-level checks for the escape-time pixel unit, bound to the top level.
// ----------------------------------------------------------------------------
module etfp_checker import etfp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] red,
  input logic [COLOR_W-1:0] green,
  input logic [COLOR_W-1:0] blue,
  input logic [COUNT_W-1:0] iteration_count,
  input logic               inside_res
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(iteration_count) && $stable(inside_res))
    else $error("stalled result item changed");

  // one pixel at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_res |-> red == '0 && green == '0 && blue == '0)
    else $error("inside pixel not black");

  // escape needs at least one step
  a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !inside_res |-> iteration_count != '0)
    else $error("escaped pixel with zero steps");

endmodule

bind escape_time_fractal_pixel_unit etfp_checker u_etfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .red             (out_chan.red),
  .green           (out_chan.green),
  .blue            (out_chan.blue),
  .iteration_count (out_chan.iteration_count),
  .inside_res      (out_chan.inside_res)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-time fractal pixel unit. Pixel items are
// pushed through the input channel under random gaps while the result channel
// stalls at random; a scoreboard recomputes the escape count and ramp color
// of every accepted pixel and matches it against the returned result item.
// Registers are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
import etfp_pkg::*;

typedef struct packed {
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COUNT_W-1:0] count;
  logic               in_set;
} pixel_color_t;

class fractal_color_scoreboard;
  localparam int     FRAC      = 28;
  localparam longint S32_MAX   = 64'sd2147483647;
  localparam longint S32_MIN   = -64'sd2147483648;
  localparam longint ESCAPE_R2 = longint'(4) << FRAC;

  logic        [COUNT_W-1:0]   iter_limit;
  logic signed [VAL_W-1:0]     org_re;
  logic signed [VAL_W-1:0]     org_im;
  logic        [STEP_W-1:0]    step;
  logic signed [VAL_W-1:0]     z0_re;
  logic signed [VAL_W-1:0]     z0_im;
  logic        [PALETTE_W-1:0] ramp_base;

  pixel_color_t expected_colors[$];
  int mismatches;
  int results_seen;
  int inside_seen;

  function new();
    iter_limit   = RST_MAX_ITERATIONS;
    org_re       = RST_ORIGIN_RE;
    org_im       = RST_ORIGIN_IM;
    step         = RST_PIXEL_STEP;
    z0_re        = RST_START_RE;
    z0_im        = RST_START_IM;
    ramp_base    = RST_PALETTE_STARTS;
    mismatches   = 0;
    results_seen = 0;
    inside_seen  = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_MAX_ITERATIONS: iter_limit = v[COUNT_W-1:0];
      CFG_ORIGIN_RE:      org_re     = v;
      CFG_ORIGIN_IM:      org_im     = v;
      CFG_PIXEL_STEP:     step       = v[STEP_W-1:0];
      CFG_START_RE:       z0_re      = v;
      CFG_START_IM:       z0_im      = v;
      CFG_PALETTE_STARTS: ramp_base  = v[PALETTE_W-1:0];
      default: ;
    endcase
  endfunction

  static function longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // one ramp segment: +3 per entry crossed, only while below the cap
  static function int unsigned ramp_up(int unsigned base, int unsigned lo,
                                       int unsigned hi, int unsigned idx);
    int unsigned lvl;
    lvl = base;
    for (int unsigned i = lo; i < hi && i < idx; i++) begin
      if (lvl < 253) lvl += 3;
    end
    return lvl;
  endfunction

  function pixel_color_t shade_pixel(logic [11:0] px, logic [11:0] py);
    pixel_color_t res;
    longint c_re, c_im, a, b, aa, bb, ab2, mag;
    int unsigned n, idx;
    c_re = clamp32(longint'(org_re) + longint'(px) * longint'(step));
    c_im = clamp32(longint'(org_im) + longint'(py) * longint'(step));
    a = longint'(z0_re);
    b = longint'(z0_im);
    n = 0;
    while (n < iter_limit) begin
      aa  = (a * a) >>> FRAC;
      bb  = (b * b) >>> FRAC;
      ab2 = (a * b) >>> (FRAC - 1);
      a = clamp32(aa - bb + c_re);
      b = clamp32(ab2 + c_im);
      n++;
      mag = ((a * a) >>> FRAC) + ((b * b) >>> FRAC);
      if (mag > ESCAPE_R2) break;
    end
    res = '0;
    res.count  = n[COUNT_W-1:0];
    res.in_set = (n == iter_limit);
    if (!res.in_set && iter_limit >= 2) begin
      idx = (n * 255) / (iter_limit - 1);
      if (idx > 255) idx = 255;
      res.red   = 8'(ramp_up(ramp_base[23:16], 0, 85, idx));
      res.green = 8'(ramp_up(ramp_base[15:8], 85, 170, idx));
      res.blue  = 8'(ramp_up(ramp_base[7:0], 170, 256, idx));
    end
    return res;
  endfunction

  function void note_pixel(logic [11:0] px, logic [11:0] py);
    expected_colors.push_back(shade_pixel(px, py));
  endfunction

  function void check_color(pixel_color_t got);
    pixel_color_t want;
    bit bad;
    results_seen++;
    if (got.in_set) inside_seen++;
    if (expected_colors.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result item with nothing expected: rgb %0d/%0d/%0d n=%0d in=%0b",
                 got.red, got.green, got.blue, got.count, got.in_set);
      return;
    end
    want = expected_colors.pop_front();
    bad = (got.red !== want.red) || (got.green !== want.green) ||
          (got.blue !== want.blue) || (got.count !== want.count) ||
          (got.in_set !== want.in_set);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d: exp rgb %0d/%0d/%0d n=%0d in=%0b, got rgb %0d/%0d/%0d n=%0d in=%0b",
                 results_seen, want.red, want.green, want.blue, want.count, want.in_set,
                 got.red, got.green, got.blue, got.count, got.in_set);
    end
  endfunction

  function int pending();
    return expected_colors.size();
  endfunction
endclass

module tb;
  localparam int TIMEOUT_CYCLES = 16_000_000;
  localparam int RANDOM_ITEMS   = 750;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bit          no_idle;
  int unsigned cycle_count;
  int          pixels_sent;
  int          setups;

  fractal_color_scoreboard colors = new();

  etfp_in_if  in_chan ();
  etfp_out_if out_chan ();

  escape_time_fractal_pixel_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, colors.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result channel back-pressure
  initial begin
    int unsigned hold;
    int unsigned r;
    bit level;
    hold = 0;
    level = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          level = 1'b1;
          hold = $urandom_range(1, 20);
        end else begin
          level = 1'b0;
          hold = pick_gap();
          if (hold == 0) hold = 1;
        end
      end
      hold--;
      out_chan.ready <= no_idle ? 1'b1 : level;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      colors.check_color(pixel_color_t'({out_chan.red, out_chan.green, out_chan.blue,
                                         out_chan.iteration_count, out_chan.inside_res}));
  end

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.pixel_x <= px;
    in_chan.pixel_y <= py;
    do @(posedge clk); while (!in_chan.ready);
    colors.note_pixel(px, py);
    pixels_sent++;
  endtask

  // wait until every result is back, then a short pause before register writes
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (colors.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    setups++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    colors.write_reg(idx, v);
  endtask

  task automatic run_directed();
    // default view after reset: corners, the origin of the plane, cardioid
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd500, 12'd300);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'd350, 12'd450);

    // zero limit: no step at all, always inside
    settle();
    write_reg(CFG_MAX_ITERATIONS, 32'd0);
    write_reg(CFG_ORIGIN_RE, 32'h0000_0000);
    write_reg(CFG_ORIGIN_IM, 32'h0000_0000);
    write_reg(CFG_PIXEL_STEP, 32'd1);
    write_reg(CFG_START_RE, 32'h1000_0000);
    write_reg(CFG_START_IM, 32'hF000_0000);
    write_reg(CFG_PALETTE_STARTS, 32'h0010_2030);
    cfg_we <= 1'b0;
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd2);

    // limit of one, plus a write to an unmapped index that must be dropped
    settle();
    write_reg(CFG_MAX_ITERATIONS, 32'd1);
    write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);

    // extremes everywhere: c and z saturate, step written with bit 31 set
    settle();
    no_idle = 1'b1;
    write_reg(CFG_MAX_ITERATIONS, 32'd2);
    write_reg(CFG_ORIGIN_RE, 32'h7FFF_FFFF);
    write_reg(CFG_ORIGIN_IM, 32'h8000_0000);
    write_reg(CFG_PIXEL_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_START_RE, 32'h8000_0000);
    write_reg(CFG_START_IM, 32'h7FFF_FFFF);
    write_reg(CFG_PALETTE_STARTS, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);

    // largest limit: c = -1 stays bounded, c = 0.28 escapes late
    settle();
    no_idle = 1'b0;
    write_reg(CFG_MAX_ITERATIONS, 32'd1023);
    write_reg(CFG_ORIGIN_RE, 32'hF000_0000);
    write_reg(CFG_ORIGIN_IM, 32'h0000_0000);
    write_reg(CFG_PIXEL_STEP, 32'd0);
    write_reg(CFG_START_RE, 32'h0000_0000);
    write_reg(CFG_START_IM, 32'h0000_0000);
    write_reg(CFG_PALETTE_STARTS, 32'h0000_0000);
    cfg_we <= 1'b0;
    send_pixel(12'd0, 12'd0);
    settle();
    write_reg(CFG_ORIGIN_RE, 32'h0480_0000);
    cfg_we <= 1'b0;
    send_pixel(12'd77, 12'd3000);
    settle();
    write_reg(CFG_ORIGIN_RE, 32'hF000_0000);
    write_reg(CFG_START_RE, 32'h0800_0000);
    write_reg(CFG_START_IM, 32'h0800_0000);
    cfg_we <= 1'b0;
    send_pixel(12'd0, 12'd0);

    // short limit, ramp starts at and around the cap, far start point
    settle();
    write_reg(CFG_MAX_ITERATIONS, 32'd10);
    write_reg(CFG_ORIGIN_RE, 32'hE000_0000);
    write_reg(CFG_ORIGIN_IM, 32'hEC00_0000);
    write_reg(CFG_PIXEL_STEP, 32'h0010_0000);
    write_reg(CFG_START_RE, 32'h2000_0000);
    write_reg(CFG_START_IM, 32'h0000_0000);
    write_reg(CFG_PALETTE_STARTS, 32'h00FD_FEFC);
    cfg_we <= 1'b0;
    send_pixel(12'd0, 12'd320);
    send_pixel(12'd400, 12'd320);
    send_pixel(12'd640, 12'd100);
    send_pixel(12'd767, 12'd640);
  endtask

  task automatic random_setup(bit deep);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    settle();
    if (deep || kind < 7) begin
      // a plausible view of the set
      write_reg(CFG_MAX_ITERATIONS, deep ? $urandom_range(200, 1023) : $urandom_range(2, 48));
      write_reg(CFG_ORIGIN_RE, $urandom_range(0, 32'h2000_0000) - 32'h2400_0000);
      write_reg(CFG_ORIGIN_IM, $urandom_range(0, 32'h1800_0000) - 32'h1800_0000);
      write_reg(CFG_PIXEL_STEP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000)
                                                            : $urandom_range(4000, 200000));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_START_RE, $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
        write_reg(CFG_START_IM, $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
      end else begin
        write_reg(CFG_START_RE, 32'h0000_0000);
        write_reg(CFG_START_IM, 32'h0000_0000);
      end
    end else begin
      // noise: any register value, limit kept modest
      write_reg(CFG_MAX_ITERATIONS, $urandom_range(0, 100) | ($urandom() & 32'hFFFF_FC00));
      write_reg(CFG_ORIGIN_RE, $urandom());
      write_reg(CFG_ORIGIN_IM, $urandom());
      write_reg(CFG_PIXEL_STEP, $urandom());
      write_reg(CFG_START_RE, $urandom());
      write_reg(CFG_START_IM, $urandom());
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_PALETTE_STARTS, {8'd0, 8'($urandom_range(240, 255)),
                                     8'($urandom_range(240, 255)), 8'($urandom_range(240, 255))});
    else
      write_reg(CFG_PALETTE_STARTS, $urandom());
    cfg_we <= 1'b0;
    no_idle = ($urandom_range(0, 4) == 0);
  endtask

  task automatic run_random();
    int sent;
    int phase_items;
    bit deep;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      deep = ($urandom_range(0, 14) == 0);
      random_setup(deep);
      phase_items = deep ? 6 : $urandom_range(15, 50);
      for (int i = 0; i < phase_items && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
        else
          send_pixel(12'($urandom()), 12'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MAX_ITERATIONS;
    cfg_wdata       <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.pixel_x <= '0;
    in_chan.pixel_y <= '0;
    no_idle     = 1'b0;
    pixels_sent = 0;
    setups      = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    settle();

    $display("covered %0d pixels over %0d register setups in %0d cycles",
             pixels_sent, setups, cycle_count);
    $display("%0d results checked (%0d inside), %0d mismatching",
             colors.results_seen, colors.inside_seen, colors.mismatches);
    if (colors.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
